// ===== design/rcfs_pkg.sv =====
package rcfs_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HDR_PRI = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_ALT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER  = 2'd2;

    localparam logic [BYTE_W-1:0] HDR_PRI_RST = 8'h0F;
    localparam logic [BYTE_W-1:0] HDR_ALT_RST = 8'hF0;
    localparam logic [BYTE_W-1:0] FOOTER_RST  = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_SRCH_RD,
        ST_SRCH_CK,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic store_in;   // write input byte at fill position, advance fill
        logic rd_src;     // read store at source pointer
        logic src_load0;  // source pointer to position 0
        logic src_load1;  // source pointer to position 1
        logic src_inc;
        logic dst_clr;
        logic shift_wr;   // write read data at destination, advance destination
        logic out_load;
        logic fill_clr;
        logic fill_set;   // fill from destination pointer plus one
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_keep;    // input byte is kept (buffer started or header)
        logic in_last;    // input byte completes the frame
        logic in_footer;  // input byte equals footer value
        logic q_header;   // read data equals a header value
        logic src_last;   // source pointer at last position
        logic out_free;   // output register can take a new item
    } t_dp_sts;

endpackage

// ===== design/rc_serial_frame_sync_core.sv =====
// A byte is taken in any cycle while the block is idle; the store has one write port.
// Frame with matching footer: each item is read from the store, then loaded into the output
// register once free; no input during the emit. Output register decouples the downstream side.
// Footer mismatch (no input meanwhile): bytes from position 1 are checked for a header; from
// the first found, they move down to position 0 (read, then write); if none, all are dropped.
// Synchronous active-low reset clears control, fill count, output valid; store is not cleared.
module rc_serial_frame_sync_core #(
    parameter int unsigned FRAME_BYTES = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rcfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcfs_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] rx_byte
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [15:0]                    o_m_tdata,   // [7:0] frame_byte, [12:8] byte_position
    output logic                           o_m_tlast    // frame_end
);

    rcfs_pkg::t_dp_cmd           w_cmd;
    rcfs_pkg::t_dp_sts           w_sts;
    logic [rcfs_pkg::BYTE_W-1:0] w_out_byte;
    logic [rcfs_pkg::POS_W-1:0]  w_out_pos;

    rcfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rcfs_dpath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_byte   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_byte  (w_out_byte),
        .o_out_pos   (w_out_pos),
        .o_out_end   (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, w_out_pos, w_out_byte};

    a_store_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.store_in |-> (i_s_tvalid && o_s_tready))
        else $error("byte stored without an accepted input item");

    a_no_overwrite_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_m_tvalid && !i_m_tready))
        else $error("output register loaded while an item is still waiting");

    a_one_store_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.store_in, w_cmd.shift_wr, w_cmd.rd_src, w_cmd.out_load}))
        else $error("conflicting store commands in one cycle");

    a_end_at_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[12:8] == rcfs_pkg::POS_W'(FRAME_BYTES - 1)))
        else $error("frame end flagged away from the last position");

endmodule

// ===== design/rcfs_ctrl.sv =====
module rcfs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rcfs_pkg::t_dp_sts i_sts,
    output rcfs_pkg::t_dp_cmd o_cmd
);

    rcfs_pkg::t_state r_state;
    rcfs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rcfs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_sts.in_keep) begin
                    o_cmd.store_in = 1'b1;
                    if (i_sts.in_last) begin
                        if (i_sts.in_footer) begin
                            o_cmd.src_load0 = 1'b1;
                            n_state         = rcfs_pkg::ST_EMIT_RD;
                        end else begin
                            o_cmd.src_load1 = 1'b1;
                            n_state         = rcfs_pkg::ST_SRCH_RD;
                        end
                    end
                end
            end
            rcfs_pkg::ST_EMIT_RD: begin
                o_cmd.rd_src = 1'b1;
                n_state      = rcfs_pkg::ST_EMIT_LD;
            end
            rcfs_pkg::ST_EMIT_LD: begin
                // hold the read data until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.src_last) begin
                        o_cmd.fill_clr = 1'b1;
                        n_state        = rcfs_pkg::ST_IDLE;
                    end else begin
                        o_cmd.src_inc = 1'b1;
                        n_state       = rcfs_pkg::ST_EMIT_RD;
                    end
                end
            end
            rcfs_pkg::ST_SRCH_RD: begin
                o_cmd.rd_src = 1'b1;
                n_state      = rcfs_pkg::ST_SRCH_CK;
            end
            rcfs_pkg::ST_SRCH_CK: begin
                priority if (i_sts.q_header) begin
                    o_cmd.dst_clr = 1'b1;
                    n_state       = rcfs_pkg::ST_SHIFT_RD;
                end else if (i_sts.src_last) begin
                    o_cmd.fill_clr = 1'b1;
                    n_state        = rcfs_pkg::ST_IDLE;
                end else begin
                    o_cmd.src_inc = 1'b1;
                    n_state       = rcfs_pkg::ST_SRCH_RD;
                end
            end
            rcfs_pkg::ST_SHIFT_RD: begin
                o_cmd.rd_src = 1'b1;
                n_state      = rcfs_pkg::ST_SHIFT_WR;
            end
            rcfs_pkg::ST_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                if (i_sts.src_last) begin
                    o_cmd.fill_set = 1'b1;
                    n_state        = rcfs_pkg::ST_IDLE;
                end else begin
                    o_cmd.src_inc = 1'b1;
                    n_state       = rcfs_pkg::ST_SHIFT_RD;
                end
            end
            default: begin
                n_state = rcfs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rcfs_dpath.sv =====
module rcfs_dpath #(
    parameter int unsigned FRAME_BYTES = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rcfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rcfs_pkg::BYTE_W-1:0]       i_cfg_data,
    input  logic [rcfs_pkg::BYTE_W-1:0]       i_in_byte,
    input  rcfs_pkg::t_dp_cmd                 i_cmd,
    output rcfs_pkg::t_dp_sts                 o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [rcfs_pkg::BYTE_W-1:0]       o_out_byte,
    output logic [rcfs_pkg::POS_W-1:0]        o_out_pos,
    output logic                              o_out_end
);

    localparam int unsigned IDX_W  = $clog2(FRAME_BYTES);
    localparam int unsigned FILL_W = $clog2(FRAME_BYTES + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(FRAME_BYTES - 1);
    localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(FRAME_BYTES - 1);

    logic [rcfs_pkg::BYTE_W-1:0] r_hdr_pri;
    logic [rcfs_pkg::BYTE_W-1:0] r_hdr_alt;
    logic [rcfs_pkg::BYTE_W-1:0] r_footer;

    logic [rcfs_pkg::BYTE_W-1:0] r_store [FRAME_BYTES];
    logic [rcfs_pkg::BYTE_W-1:0] r_mem_q;
    logic [FILL_W-1:0]           r_fill;
    logic [IDX_W-1:0]            r_src;
    logic [IDX_W-1:0]            r_dst;

    logic                        r_out_valid;
    logic [rcfs_pkg::BYTE_W-1:0] r_out_byte;
    logic [rcfs_pkg::POS_W-1:0]  r_out_pos;
    logic                        r_out_end;

    logic                        w_we;
    logic [IDX_W-1:0]            w_waddr;
    logic [rcfs_pkg::BYTE_W-1:0] w_wdata;
    logic                        w_in_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pri <= rcfs_pkg::HDR_PRI_RST;
            r_hdr_alt <= rcfs_pkg::HDR_ALT_RST;
            r_footer  <= rcfs_pkg::FOOTER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcfs_pkg::CFG_HDR_PRI: r_hdr_pri <= i_cfg_data;
                rcfs_pkg::CFG_HDR_ALT: r_hdr_alt <= i_cfg_data;
                rcfs_pkg::CFG_FOOTER:  r_footer  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // single write port: incoming byte at the fill position, or a moved-down byte
    assign w_we    = i_cmd.store_in | i_cmd.shift_wr;
    assign w_waddr = i_cmd.store_in ? r_fill[IDX_W-1:0] : r_dst;
    assign w_wdata = i_cmd.store_in ? i_in_byte : r_mem_q;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_src) begin
            r_mem_q <= r_store[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.fill_clr) begin
            r_fill <= '0;
        end else if (i_cmd.fill_set) begin
            r_fill <= FILL_W'(r_dst) + FILL_W'(1);
        end else if (i_cmd.store_in) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.src_load0) begin
            r_src <= '0;
        end else if (i_cmd.src_load1) begin
            r_src <= IDX_W'(1);
        end else if (i_cmd.src_inc) begin
            r_src <= r_src + IDX_W'(1);
        end
        if (i_cmd.dst_clr) begin
            r_dst <= '0;
        end else if (i_cmd.shift_wr) begin
            r_dst <= r_dst + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte <= r_mem_q;
            r_out_pos  <= rcfs_pkg::POS_W'(r_src);
            r_out_end  <= (r_src == LAST_IDX);
        end
    end

    assign w_in_hdr = (i_in_byte == r_hdr_pri) || (i_in_byte == r_hdr_alt);

    always_comb begin
        o_sts.in_keep   = (r_fill != '0) || w_in_hdr;
        o_sts.in_last   = (r_fill == LAST_FILL);
        o_sts.in_footer = (i_in_byte == r_footer);
        o_sts.q_header  = (r_mem_q == r_hdr_pri) || (r_mem_q == r_hdr_alt);
        o_sts.src_last  = (r_src == LAST_IDX);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_pos   = r_out_pos;
    assign o_out_end   = r_out_end;

endmodule
